/* sv/ils_pkg.sv */
// ---------------------------------------------------------------------------
// ils_pkg
// Shared types and fixed widths for the interval level statistics block.
// ---------------------------------------------------------------------------
package ils_pkg;

    localparam int TS_BITS       = 64;
    localparam int INTERVAL_BITS = 48;
    localparam int SUM_BITS      = 40;
    localparam int MEAN_BITS     = 24;
    localparam int FRAC_BITS     = 8;
    // mean overflows its field when |sum| >= count << SAT_SHIFT
    localparam int SAT_SHIFT     = MEAN_BITS - FRAC_BITS;
    localparam int ITER_BITS     = $clog2(MEAN_BITS);

    typedef struct packed {
        logic update;   // fold the held item into the window
        logic restart;  // close the window: clear accumulators, restart at timestamp
    } acc_ctrl_t;

endpackage

/* sv/interval_level_statistics.sv */
// ---------------------------------------------------------------------------
// interval_level_statistics
// Windowed min / max / sum / count / Q8 mean of frame levels.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one frame transaction: timestamp,
// level flag and signed level. Config channel (cfg_valid/cfg_ready) writes
// interval_ns, always ready; the user must write it only while the block
// idles (unenforced). A closed window yields one out_valid/out_ready result.
//
// A frame that closes no window passes through capture and accumulate.
// A frame that closes a window passes through capture, accumulate, divider
// load, 24 divider steps (one quotient bit per cycle through a single
// compare/subtract unit), a check that the divider has finished, and emit.
// Empty or saturating windows skip the steps. in_ready is high only while
// the sequencer idles.
//
// Reset clears the accumulators, the window start and interval_ns.
// The result sits in an output register; the next frame is taken while it
// waits. A new result waits in the emit step until the old one is taken.
// ---------------------------------------------------------------------------
module interval_level_statistics #(
    parameter int LEVEL_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ils_pkg::TS_BITS-1:0]           timestamp_ns,
    input  logic                                  has_level,
    input  logic signed [LEVEL_BITS-1:0]          level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ils_pkg::INTERVAL_BITS-1:0]     interval_ns,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [COUNT_BITS-1:0]                 sample_count,
    output logic signed [ils_pkg::SUM_BITS-1:0]   level_sum,
    output logic signed [LEVEL_BITS-1:0]          level_min,
    output logic signed [LEVEL_BITS-1:0]          level_max,
    output logic signed [ils_pkg::MEAN_BITS-1:0]  mean_q8,
    output logic                                  mean_valid
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ACCUM  = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ils_pkg::TS_BITS-1:0]        ts_reg;
    logic                               has_reg;
    logic signed [LEVEL_BITS-1:0]       level_reg;
    logic [ils_pkg::INTERVAL_BITS-1:0]  interval_reg;

    ils_pkg::acc_ctrl_t                 acc_ctrl;
    logic                               fire;
    logic [COUNT_BITS-1:0]              acc_count;
    logic signed [ils_pkg::SUM_BITS-1:0] acc_sum;
    logic signed [LEVEL_BITS-1:0]       acc_min, acc_max;

    logic                               div_start, div_busy;
    logic signed [ils_pkg::MEAN_BITS-1:0] div_mean;
    logic                               div_mean_valid;

    logic                               out_free, emit;
    logic                               out_valid_reg, out_valid_next;

    logic [COUNT_BITS-1:0]              count_out_reg;
    logic signed [ils_pkg::SUM_BITS-1:0] sum_out_reg;
    logic signed [LEVEL_BITS-1:0]       min_out_reg, max_out_reg;
    logic signed [ils_pkg::MEAN_BITS-1:0] mean_out_reg;
    logic                               mean_valid_out_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next       = state_reg;
        acc_ctrl.update  = 1'b0;
        acc_ctrl.restart = 1'b0;
        div_start        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                acc_ctrl.update = 1'b1;
                state_next      = fire ? S_LAUNCH : S_IDLE;
            end
            S_LAUNCH:
            begin
                div_start  = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (!div_busy)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    acc_ctrl.restart = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            interval_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                interval_reg <= interval_ns;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ts_reg    <= timestamp_ns;
            has_reg   <= has_level;
            level_reg <= level;
        end
        if (emit)
        begin
            count_out_reg      <= acc_count;
            sum_out_reg        <= acc_sum;
            min_out_reg        <= acc_min;
            max_out_reg        <= acc_max;
            mean_out_reg       <= div_mean;
            mean_valid_out_reg <= div_mean_valid;
        end
    end

    ils_acc #(
        .LEVEL_BITS (LEVEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (acc_ctrl),
        .timestamp_ns (ts_reg),
        .has_level    (has_reg),
        .level        (level_reg),
        .interval_ns  (interval_reg),
        .fire         (fire),
        .acc_count    (acc_count),
        .acc_sum      (acc_sum),
        .acc_min      (acc_min),
        .acc_max      (acc_max)
    );

    ils_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .acc_sum    (acc_sum),
        .acc_count  (acc_count),
        .busy       (div_busy),
        .mean_q8    (div_mean),
        .mean_valid (div_mean_valid)
    );

    assign out_valid    = out_valid_reg;
    assign sample_count = count_out_reg;
    assign level_sum    = sum_out_reg;
    assign level_min    = min_out_reg;
    assign level_max    = max_out_reg;
    assign mean_q8      = mean_out_reg;
    assign mean_valid   = mean_valid_out_reg;

endmodule

/* sv/ils_acc.sv */
// ---------------------------------------------------------------------------
// ils_acc
// Window accumulators (sum, min, max, count), window start and window test.
// ---------------------------------------------------------------------------
module ils_acc #(
    parameter int LEVEL_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ils_pkg::acc_ctrl_t                   ctrl,
    input  logic [ils_pkg::TS_BITS-1:0]          timestamp_ns,
    input  logic                                 has_level,
    input  logic signed [LEVEL_BITS-1:0]         level,
    input  logic [ils_pkg::INTERVAL_BITS-1:0]    interval_ns,
    output logic                                 fire,
    output logic [COUNT_BITS-1:0]                acc_count,
    output logic signed [ils_pkg::SUM_BITS-1:0]  acc_sum,
    output logic signed [LEVEL_BITS-1:0]         acc_min,
    output logic signed [LEVEL_BITS-1:0]         acc_max
);

    localparam int SB = ils_pkg::SUM_BITS;
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_HI = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    localparam logic signed [SB-1:0] SUM_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SUM_LO = {1'b1, {(SB-1){1'b0}}};

    logic [ils_pkg::TS_BITS-1:0]  start_reg, start_next, start_eff, elapsed;
    logic signed [SB-1:0]         sum_reg, sum_next;
    logic signed [LEVEL_BITS-1:0] min_reg, min_next, max_reg, max_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic signed [SB:0]           sum_wide;

    always_comb
    begin
        start_eff = (start_reg == '0) ? timestamp_ns : start_reg;
        elapsed   = timestamp_ns - start_eff;
        fire      = (interval_ns != '0) && (elapsed >= ils_pkg::TS_BITS'(interval_ns));
        sum_wide  = (SB+1)'(sum_reg) + (SB+1)'(level);
    end

    always_comb
    begin
        start_next = start_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        if (ctrl.restart)
        begin
            start_next = timestamp_ns;
            sum_next   = '0;
            min_next   = LEVEL_HI;
            max_next   = '0;
            count_next = '0;
        end
        else if (ctrl.update)
        begin
            start_next = start_eff;
            if (has_level)
            begin
                if (sum_wide[SB] != sum_wide[SB-1])
                    sum_next = sum_wide[SB] ? SUM_LO : SUM_HI;
                else
                    sum_next = sum_wide[SB-1:0];
                if (level > max_reg)
                    max_next = level;
                if (level < min_reg)
                    min_next = level;
                if (count_reg != '1)
                    count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= LEVEL_HI;
            max_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
        end
    end

    assign acc_count = count_reg;
    assign acc_sum   = sum_reg;
    assign acc_min   = min_reg;
    assign acc_max   = max_reg;

endmodule

/* sv/ils_div.sv */
// ---------------------------------------------------------------------------
// ils_div
// Serial restoring divider for the signed Q8 mean, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module ils_div #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [ils_pkg::SUM_BITS-1:0]   acc_sum,
    input  logic [COUNT_BITS-1:0]                 acc_count,
    output logic                                  busy,
    output logic signed [ils_pkg::MEAN_BITS-1:0]  mean_q8,
    output logic                                  mean_valid
);

    localparam int SB    = ils_pkg::SUM_BITS;
    localparam int MB    = ils_pkg::MEAN_BITS;
    localparam int SS    = ils_pkg::SAT_SHIFT;
    localparam int FB    = ils_pkg::FRAC_BITS;
    localparam int IB    = ils_pkg::ITER_BITS;
    localparam int TOP_W = SB - SS;
    localparam int RW    = COUNT_BITS + 1;
    localparam int EXT_W = (TOP_W > COUNT_BITS) ? TOP_W : COUNT_BITS;
    localparam int CMP_W = SB + COUNT_BITS;
    localparam logic [MB-1:0] POS_LIM = {1'b0, {(MB-1){1'b1}}};
    localparam logic [MB-1:0] NEG_LIM = {1'b1, {(MB-1){1'b0}}};

    logic [SB-1:0]         mag;
    logic                  sat;
    logic [EXT_W-1:0]      top_ext;
    logic [RW-1:0]         shifted;
    logic [RW:0]           trial;
    logic                  ge;

    logic                  busy_reg, busy_next;
    logic [IB-1:0]         iter_reg, iter_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [MB-1:0]         work_reg, work_next;
    logic                  neg_reg, neg_next;
    logic                  sat_reg, sat_next;
    logic                  valid_reg, valid_next;

    always_comb
    begin
        mag     = acc_sum[SB-1] ? SB'(-acc_sum) : SB'(acc_sum);
        sat     = CMP_W'(mag) >= (CMP_W'(acc_count) << SS);
        top_ext = EXT_W'(mag[SB-1:SS]);
        shifted = {rem_reg, work_reg[MB-1]};
        trial   = {1'b0, shifted} - (RW+1)'(acc_count);
        ge      = !trial[RW];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        iter_next  = iter_reg;
        rem_next   = rem_reg;
        work_next  = work_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        valid_next = valid_reg;
        if (start)
        begin
            neg_next   = acc_sum[SB-1];
            valid_next = acc_count != '0;
            sat_next   = sat;
            busy_next  = (acc_count != '0) && !sat;
            iter_next  = IB'(MB - 1);
            rem_next   = COUNT_BITS'(top_ext);
            work_next  = {mag[SS-1:0], {FB{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            work_next = {work_reg[MB-2:0], ge};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            iter_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            iter_reg  <= iter_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
    end

    always_comb
    begin
        if (!valid_reg)
            mean_q8 = '0;
        else if (neg_reg)
            mean_q8 = (sat_reg || (work_reg > NEG_LIM)) ? NEG_LIM : MB'(-work_reg);
        else
            mean_q8 = (sat_reg || work_reg[MB-1]) ? POS_LIM : work_reg;
    end

    assign busy       = busy_reg;
    assign mean_valid = valid_reg;

endmodule
